### sv/vpn_pkg.sv
package vpn_pkg;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  localparam logic [15:0] BUF_BYTES_RESET = 16'd256;

  // classified-item queue
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DRIVE    = 3'd1,
    ST_DOUBLE   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_DOTDOT   = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_t;

  // one classified input item: which results it causes, in output order
  typedef struct packed {
    logic    has_sep;
    logic    has_byte;
    logic    has_stat;
    logic [7:0] data;
    status_t status;
  } rec_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage

### sv/vpn_front.sv
module vpn_front #(
  parameter int COUNT_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata,
  input  logic          acc,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  output vpn_pkg::rec_t rec,
  output logic          rec_push
);
  import vpn_pkg::*;

  localparam int CW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

  logic [15:0]           buf_r;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                  pend_r, pend_nxt;
  logic [1:0]            rpos_r, rpos_nxt;
  logic                  fra_r, fra_nxt;
  logic                  frs_r, frs_nxt;
  logic                  rdrv_r, rdrv_nxt;
  logic                  rdbl_r, rdbl_nxt;
  logic                  foa_r, foa_nxt;
  logic                  odrv_r, odrv_nxt;
  logic [1:0]            slen_r, slen_nxt;
  logic                  dots_r, dots_nxt;
  logic                  par_r, par_nxt;
  logic                  ovf_r, ovf_nxt;

  logic       raw_sep;
  logic [7:0] c;
  logic       no_room;
  logic       len_zero;

  assign raw_sep = (in_byte == CH_SLASH) || (in_byte == CH_BSLASH);
  assign c       = (in_byte == CH_BSLASH) ? CH_SLASH : in_byte;
  // write at count n overflows when n + 1 >= buffer size
  assign no_room = ({{(CW-COUNT_BITS){1'b0}}, cnt_r} + CW'(1)) >= {{(CW-16){1'b0}}, buf_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    pend_nxt = pend_r;
    rpos_nxt = rpos_r;
    fra_nxt  = fra_r;
    frs_nxt  = frs_r;
    rdrv_nxt = rdrv_r;
    rdbl_nxt = rdbl_r;
    foa_nxt  = foa_r;
    odrv_nxt = odrv_r;
    slen_nxt = slen_r;
    dots_nxt = dots_r;
    par_nxt  = par_r;
    ovf_nxt  = ovf_r;
    len_zero = 1'b0;
    rec          = '0;
    rec.data     = c;
    rec.status   = ST_OK;

    if (rpos_r == 2'd0) begin
      fra_nxt  = is_letter(in_byte);
      frs_nxt  = raw_sep;
      rpos_nxt = 2'd1;
    end else if (rpos_r == 2'd1) begin
      rdrv_nxt = fra_r && (in_byte == CH_COLON);
      rdbl_nxt = frs_r && raw_sep;
      rpos_nxt = 2'd2;
    end

    if (!ovf_r) begin
      if (c == CH_SLASH) begin
        if (cnt_r != '0 && !pend_r) begin
          if (no_room) begin
            ovf_nxt = 1'b1;
          end else begin
            if (slen_r == 2'd2 && dots_r) par_nxt = 1'b1;
            slen_nxt = 2'd0;
            dots_nxt = 1'b1;
            if (cnt_r != '1) cnt_nxt = cnt_r + COUNT_BITS'(1);
            pend_nxt = 1'b1;
          end
        end
      end else if (no_room) begin
        ovf_nxt = 1'b1;
      end else begin
        if (pend_r) begin
          rec.has_sep = 1'b1;
          pend_nxt    = 1'b0;
        end
        if (cnt_r == '0) foa_nxt = is_letter(c);
        else if (cnt_r == COUNT_BITS'(1)) odrv_nxt = foa_r && (c == CH_COLON);
        if (slen_r != 2'd3) slen_nxt = slen_r + 2'd1;
        if (c != CH_DOT) dots_nxt = 1'b0;
        rec.has_byte = 1'b1;
        if (cnt_r != '1) cnt_nxt = cnt_r + COUNT_BITS'(1);
      end
    end

    if (in_last) begin
      if (slen_nxt == 2'd2 && dots_nxt) par_nxt = 1'b1;
      len_zero = (cnt_nxt == '0) || ((cnt_nxt == COUNT_BITS'(1)) && pend_nxt);
      rec.has_stat = 1'b1;
      if (rdrv_nxt)      rec.status = ST_DRIVE;
      else if (rdbl_nxt) rec.status = ST_DOUBLE;
      else if (ovf_nxt)  rec.status = ST_OVERFLOW;
      else if (len_zero) rec.status = ST_EMPTY;
      else if (odrv_nxt) rec.status = ST_DRIVE;
      else if (par_nxt)  rec.status = ST_DOTDOT;
      else               rec.status = ST_OK;
      // path done: back to the start-of-path state
      cnt_nxt  = '0;
      pend_nxt = 1'b0;
      rpos_nxt = 2'd0;
      fra_nxt  = 1'b0;
      frs_nxt  = 1'b0;
      rdrv_nxt = 1'b0;
      rdbl_nxt = 1'b0;
      foa_nxt  = 1'b0;
      odrv_nxt = 1'b0;
      slen_nxt = 2'd0;
      dots_nxt = 1'b1;
      par_nxt  = 1'b0;
      ovf_nxt  = 1'b0;
    end
  end

  assign rec_push = acc && (rec.has_sep || rec.has_byte || rec.has_stat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r  <= BUF_BYTES_RESET;
      cnt_r  <= '0;
      pend_r <= 1'b0;
      rpos_r <= 2'd0;
      fra_r  <= 1'b0;
      frs_r  <= 1'b0;
      rdrv_r <= 1'b0;
      rdbl_r <= 1'b0;
      foa_r  <= 1'b0;
      odrv_r <= 1'b0;
      slen_r <= 2'd0;
      dots_r <= 1'b1;
      par_r  <= 1'b0;
      ovf_r  <= 1'b0;
    end else begin
      if (cfg_we) buf_r <= cfg_wdata;
      if (acc) begin
        cnt_r  <= cnt_nxt;
        pend_r <= pend_nxt;
        rpos_r <= rpos_nxt;
        fra_r  <= fra_nxt;
        frs_r  <= frs_nxt;
        rdrv_r <= rdrv_nxt;
        rdbl_r <= rdbl_nxt;
        foa_r  <= foa_nxt;
        odrv_r <= odrv_nxt;
        slen_r <= slen_nxt;
        dots_r <= dots_nxt;
        par_r  <= par_nxt;
        ovf_r  <= ovf_nxt;
      end
    end
  end

endmodule

### sv/vpn_queue.sv
module vpn_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  vpn_pkg::rec_t wr_rec,
  output logic          q_full,
  input  logic          rd_en,
  output vpn_pkg::rec_t rd_rec,
  output logic          q_empty
);
  import vpn_pkg::*;

  rec_t           mem [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;

  assign q_full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign rd_rec  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wp_r] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + QAW'(1);
      if (rd_en) rp_r <= rp_r + QAW'(1);
      if (wr_en && !rd_en)      cnt_r <= cnt_r + (QAW+1)'(1);
      else if (rd_en && !wr_en) cnt_r <= cnt_r - (QAW+1)'(1);
    end
  end

endmodule

### sv/vpn_back.sv
module vpn_back (
  input  logic          clk,
  input  logic          rst_n,
  input  vpn_pkg::rec_t head,
  input  logic          q_empty,
  output logic          q_pop,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic          out_byte_valid,
  output logic          out_done_res,
  output logic [2:0]    out_status
);
  import vpn_pkg::*;

  logic       vld_r;
  logic [2:0] used_r, used_nxt;  // {stat, byte, sep} already sent
  logic [7:0] byte_r, byte_nxt;
  logic       bv_r, bv_nxt;
  logic       done_r, done_nxt;
  status_t    st_r, st_nxt;
  logic [2:0] rem, pick;
  logic       load;

  assign load = !q_empty && (!vld_r || pop);
  assign rem  = {head.has_stat, head.has_byte, head.has_sep} & ~used_r;

  always_comb begin
    pick     = 3'b000;
    byte_nxt = 8'h00;
    bv_nxt   = 1'b0;
    done_nxt = 1'b0;
    st_nxt   = ST_OK;
    if (rem[0]) begin
      pick     = 3'b001;
      byte_nxt = CH_SLASH;
      bv_nxt   = 1'b1;
    end else if (rem[1]) begin
      pick     = 3'b010;
      byte_nxt = head.data;
      bv_nxt   = 1'b1;
    end else begin
      pick     = 3'b100;
      done_nxt = 1'b1;
      st_nxt   = head.status;
    end
    q_pop    = load && ((rem & ~pick) == 3'b000);
    used_nxt = q_pop ? 3'b000 : (used_r | pick);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      used_r <= 3'b000;
    end else begin
      if (load) begin
        vld_r  <= 1'b1;
        used_r <= used_nxt;
      end else if (pop) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      bv_r   <= bv_nxt;
      done_r <= done_nxt;
      st_r   <= st_nxt;
    end
  end

  assign empty          = !vld_r;
  assign out_byte       = byte_r;
  assign out_byte_valid = bv_r;
  assign out_done_res   = done_r;
  assign out_status     = st_r;

endmodule

### sv/virtual_path_normalizer.sv
// Streaming path normalizer. A path enters one byte per cycle on push/full,
// in_last marking its final byte; backslashes turn into slashes, leading
// slashes are dropped, runs collapse and a slash is only released when a
// later ordinary byte follows, so trailing slashes vanish. Results leave on
// empty/pop: emitted bytes (out_byte_valid=1), and after the last byte one
// status transaction (out_done_res=1, out_status). Discard the bytes of a
// path whose status is not ok. Input rate is one byte per cycle; each byte
// causes zero to three results (held slash, the byte, the status), and the
// output register delivers one result per cycle, so the sustained rate is
// set by the result count at the back end. A four-entry queue of classified
// bytes decouples the two sides. The user must write buffer_bytes (cfg_we/
// cfg_wdata) only while idle (not enforced by the block); reset value 256.
module virtual_path_normalizer #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  // input transactions
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  // result transactions
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_done_res,
  output logic [2:0]  out_status
);
  import vpn_pkg::*;

  rec_t f_rec, q_head;
  logic f_push, q_full, q_empty, q_pop, acc;

  assign full = q_full;
  assign acc  = push && !q_full;

  // front: path state, classification of each byte into its results
  vpn_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .rec       (f_rec),
    .rec_push  (f_push)
  );

  // bytes that cause no result never enter the queue
  vpn_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (f_push),
    .wr_rec  (f_rec),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_rec  (q_head),
    .q_empty (q_empty)
  );

  // back: expands one queue entry into its result transactions
  vpn_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .pop            (pop),
    .empty          (empty),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_done_res   (out_done_res),
    .out_status     (out_status)
  );

endmodule

### sv/vpn_checker.sv
module vpn_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       out_byte_valid,
  input logic       out_done_res,
  input logic [2:0] out_status
);
  import vpn_pkg::*;

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result side not empty after reset");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_byte_valid != out_done_res))
    else $error("result is neither one byte nor one status");

  a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_byte_valid) |-> (out_status == ST_OK))
    else $error("byte transaction carries a status");

  a_stat_range: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_done_res) |-> (out_status <= ST_OVERFLOW && out_byte == 8'h00))
    else $error("bad status transaction");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_status)))
    else $error("waiting result changed");

endmodule

bind virtual_path_normalizer vpn_checker u_vpn_checker (.*);
